FILE: rtl/core/nnis_pkg.sv
// Package for the nearest-neighbor image scaler.
// Holds field widths, register and function codes, and the command and status types
// shared by the controller and the datapath. Depends on nothing.
package nnis_pkg;

    localparam int SIDE_W   = 9;           // source side register width
    localparam int FACTOR_W = 16;          // Q8.8 scale factor
    localparam int COORD_W  = 16;          // output coordinate width
    localparam int QUO_W    = COORD_W + 8; // quotient of (coord * 256) / factor
    localparam int IDX_W    = 18;          // sy * sw + sx with 9-bit sides
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 64;         // pixel_out, out_x, out_y

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef struct packed {
        logic load_wr;    // write the accepted pixel into the frame store
        logic size_en;    // latch clamped sides and output sizes
        logic div_start;  // launch both coordinate divisions
        logic coord_en;   // latch clamped source coordinates
        logic addr_en;    // latch frame store index
        logic rd_en;      // read the frame store
        logic out_load;   // load the output register, advance the scan
    } nnis_cmd_t;

    typedef struct packed {
        logic empty_hit;  // no output pixel remains at the scan position
        logic div_busy;   // coordinate division in progress
        logic out_free;   // output register can take a new result
    } nnis_status_t;

    // Clamp a side register to 1..max_side.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s,
                                                     input logic [SIDE_W:0] max_side);
        logic [SIDE_W-1:0] r;
        if (s == '0)
            r = SIDE_W'(1);
        else if ({1'b0, s} > max_side)
            r = SIDE_W'(max_side);
        else
            r = s;
        return r;
    endfunction

    // Output size floor(factor * side / 256), saturated; factor zero passes the side.
    function automatic logic [COORD_W-1:0] out_size(input logic [FACTOR_W-1:0] f,
                                                    input logic [SIDE_W-1:0] side);
        logic [FACTOR_W+SIDE_W-1:0] prod;
        logic [FACTOR_W+SIDE_W-9:0] scaled;
        logic [COORD_W-1:0] r;
        prod   = f * side;
        scaled = prod[FACTOR_W+SIDE_W-1:8];
        if (f == '0)
            r = COORD_W'(side);
        else if (scaled[FACTOR_W+SIDE_W-9])
            r = '1;
        else
            r = scaled[COORD_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/nnis_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port with read enable. Depends on nothing.
module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/nnis_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used for the source coordinate; depends on nothing.
module nnis_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not go negative
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], ~diff[DVS_W]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/nnis_ctrl.sv
// Controller state machine of the nearest-neighbor image scaler.
// Sequences one item at a time through the datapath; uses nnis_pkg.
module nnis_ctrl
    import nnis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_valid,
    input  logic         s_func,
    output logic         s_ready,
    input  nnis_status_t status,
    output nnis_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SIZE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_COORD = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (s_func == FUNC_REQUEST)
                        state_next = ST_SIZE;
                    else
                        cmd.load_wr = 1'b1;
                end
            end
            ST_SIZE:
            begin
                cmd.size_en = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.empty_hit)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_COORD;
            end
            ST_COORD:
            begin
                cmd.coord_en = 1'b1;
                state_next   = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/core/nnis_dp.sv
// Datapath of the nearest-neighbor image scaler: registers, scan counters,
// frame store, coordinate dividers and output register. Uses nnis_pkg,
// nnis_ram and nnis_div.
module nnis_dp
    import nnis_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [31:0]          pixel_in,
    input  nnis_cmd_t            cmd,
    output nnis_status_t         status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_data,
    output logic                 m_last,
    output logic                 m_empty
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LCNT_W = $clog2(DEPTH + 1);
    localparam logic [SIDE_W:0] MAX_SIDE_V =
        (MAX_SIDE > 511) ? {1'b0, {SIDE_W{1'b1}}} : (SIDE_W+1)'(MAX_SIDE);

    logic [SIDE_W-1:0]   src_width_reg, src_height_reg;
    logic [FACTOR_W-1:0] scale_reg;
    logic [LCNT_W-1:0]   load_count_reg;
    logic [COORD_W-1:0]  emit_col_reg, emit_row_reg;
    logic                frame_done_reg;

    logic [SIDE_W-1:0]   sw_reg, sh_reg, sx_reg, sy_reg;
    logic [COORD_W-1:0]  ow_reg, oh_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic                out_valid_reg;
    logic [31:0]         out_pix_reg;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic                out_last_reg, out_empty_reg;

    logic                store_wr;
    logic [PIXEL_BITS-1:0] rd_pix;
    logic                div_x_busy, div_y_busy;
    logic [QUO_W-1:0]    quo_x, quo_y, sx_full, sy_full;
    logic                empty_hit, out_free;
    logic                row_wrap, col_wrap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIDE_W'(1);
            src_height_reg <= SIDE_W'(1);
            scale_reg      <= FACTOR_W'(256);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIDE_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SIDE_W-1:0];
                CFG_SCALE:      scale_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // frame store
    assign store_wr = cmd.load_wr && (load_count_reg < LCNT_W'(DEPTH));

    nnis_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (ADDR_W'(load_count_reg)),
        .wr_data (PIXEL_BITS'(pixel_in)),
        .rd_en   (cmd.rd_en),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (rd_pix)
    );

    // coordinate dividers: floor(o * 256 / factor)
    nnis_div #(
        .DVD_W (QUO_W),
        .DVS_W (FACTOR_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({emit_col_reg, 8'd0}),
        .divisor  (scale_reg),
        .busy     (div_x_busy),
        .quotient (quo_x)
    );

    nnis_div #(
        .DVD_W (QUO_W),
        .DVS_W (FACTOR_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({emit_row_reg, 8'd0}),
        .divisor  (scale_reg),
        .busy     (div_y_busy),
        .quotient (quo_y)
    );

    assign sx_full = (scale_reg == '0) ? QUO_W'(emit_col_reg) : quo_x;
    assign sy_full = (scale_reg == '0) ? QUO_W'(emit_row_reg) : quo_y;

    // per-request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.size_en)
        begin
            sw_reg <= clamp_side(src_width_reg, MAX_SIDE_V);
            sh_reg <= clamp_side(src_height_reg, MAX_SIDE_V);
            ow_reg <= out_size(scale_reg, clamp_side(src_width_reg, MAX_SIDE_V));
            oh_reg <= out_size(scale_reg, clamp_side(src_height_reg, MAX_SIDE_V));
        end
        if (cmd.coord_en)
        begin
            sx_reg <= (sx_full >= QUO_W'(sw_reg)) ? sw_reg - SIDE_W'(1)
                                                  : sx_full[SIDE_W-1:0];
            sy_reg <= (sy_full >= QUO_W'(sh_reg)) ? sh_reg - SIDE_W'(1)
                                                  : sy_full[SIDE_W-1:0];
        end
        if (cmd.addr_en)
        begin
            // widen before the product so the full row offset is kept
            idx_reg <= IDX_W'(sy_reg) * IDX_W'(sw_reg) + IDX_W'(sx_reg);
        end
    end

    assign empty_hit = frame_done_reg || (emit_col_reg >= ow_reg) || (emit_row_reg >= oh_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign row_wrap  = ({1'b0, emit_row_reg} + 17'd1) >= {1'b0, oh_reg};
    assign col_wrap  = ({1'b0, emit_col_reg} + 17'd1) >= {1'b0, ow_reg};

    // scan and load counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            emit_col_reg   <= '0;
            emit_row_reg   <= '0;
            frame_done_reg <= 1'b0;
        end
        else
        begin
            if (store_wr)
            begin
                load_count_reg <= load_count_reg + LCNT_W'(1);
            end
            if (cmd.out_load && !empty_hit)
            begin
                if (!row_wrap)
                begin
                    emit_row_reg <= emit_row_reg + COORD_W'(1);
                end
                else
                begin
                    emit_row_reg <= '0;
                    if (!col_wrap)
                    begin
                        emit_col_reg <= emit_col_reg + COORD_W'(1);
                    end
                    else
                    begin
                        emit_col_reg   <= '0;
                        frame_done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (empty_hit)
            begin
                out_pix_reg   <= '0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_last_reg  <= 1'b0;
                out_empty_reg <= 1'b1;
            end
            else
            begin
                out_pix_reg   <= 32'(rd_pix);
                out_x_reg     <= emit_col_reg;
                out_y_reg     <= emit_row_reg;
                out_last_reg  <= row_wrap && col_wrap;
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign status.empty_hit = empty_hit;
    assign status.div_busy  = div_x_busy || div_y_busy;
    assign status.out_free  = out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = {out_y_reg, out_x_reg, out_pix_reg};
    assign m_last  = out_last_reg;
    assign m_empty = out_empty_reg;

`ifndef ASSERT_OFF
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register loaded while holding an untaken result");

    a_frame_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done_reg |=> frame_done_reg)
        else $error("frame done flag cleared without reset");

    a_load_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= LCNT_W'(DEPTH))
        else $error("load count ran past the frame store depth");

    a_scan_at_origin_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_done_reg) |-> (emit_col_reg == '0 && emit_row_reg == '0))
        else $error("scan not returned to origin at end of frame");
`endif

endmodule

FILE: rtl/core/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler, top level: controller plus datapath.
// A request steps through size, check, divide (24 quotient bits), clamp, index and read,
// then loads the output register; an empty request goes from check straight to the output.
// One item at a time: a new transfer is accepted only after a request's result is loaded.
// Reset (rst_n, async, active low) clears the scan, load count and registers; the frame
// store is not cleared and holds garbage until loaded.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,   // 0 src_width, 1 src_height, 2 scale_factor
    input  logic [CFG_W-1:0]     cfg_data,
    // input item stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [31:0] pixel_in
    input  logic                 s_axis_tuser,  // [0] func
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,  // [31:0] pixel_out, [47:32] out_x, [63:48] out_y
    output logic                 m_axis_tlast,  // last_pixel
    output logic                 m_axis_tuser   // [0] empty_res
);

    nnis_cmd_t    cmd;
    nnis_status_t status;

    // Register writes are always taken; the user writes only while the block is idle.
    assign cfg_ready = 1'b1;

    // Controller: accepts one transfer when idle, then steps the datapath.
    nnis_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_func  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: frame store, dividers, scan counters and the output register,
    // which holds a finished result so the next item can be accepted meanwhile.
    nnis_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast),
        .m_empty   (m_axis_tuser)
    );

endmodule

FILE: verif/nearest_neighbor_image_scaler_test.sv
// Self-checking testbench for the nearest-neighbor image scaler.
// Drives loads and pixel requests, predicts every scaled pixel in step with the block and
// compares field by field. Depends on nnis_pkg and the scaler top level only.
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_test;

    import nnis_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int SETTLE_CYCLES = 40;    // longer than one request, so a trailing load is done
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer anywhere before giving up
    localparam int REPORT_LIMIT  = 100;   // keep the log readable when the block is badly off

    // One input item: a load carries a pixel, a request carries an ignored word.
    typedef struct {
        logic        func;
        logic [31:0] pixel;
    } scaler_item_t;

    // One scaled pixel as the block should deliver it.
    typedef struct {
        logic [31:0] pixel;
        logic [15:0] col;
        logic [15:0] row;
        logic        is_last;
        logic        is_empty;
    } scaled_pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // [31:0] pixel_in
    logic                 s_axis_tuser;   // [0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // [31:0] pixel_out, [47:32] out_x, [63:48] out_y
    logic                 m_axis_tlast;   // last_pixel
    logic                 m_axis_tuser;   // [0] empty_res

    // Stimulus waiting for the driver, and pixels predicted but not yet seen.
    scaler_item_t  pending_items[$];
    scaled_pixel_t pixels_due[$];
    scaler_item_t  next_item;
    scaled_pixel_t want;

    // Shadow of the block: frame store, scan position and registers.
    bit   [31:0] frame_pixels [STORE_DEPTH];
    int unsigned loaded_count   = 0;
    int unsigned scan_col       = 0;
    int unsigned scan_row       = 0;
    logic        frame_finished = 1'b0;
    logic [8:0]  width_reg      = 9'd1;
    logic [8:0]  height_reg     = 9'd1;
    logic [15:0] factor_reg     = 16'd256;

    int   send_gap_pct   = 21;
    int   recv_stall_pct = 59;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    logic item_taken     = 1'b0;

    nearest_neighbor_image_scaler #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Out-of-range side registers act as the nearest legal side.
    function automatic int unsigned side_of(input logic [8:0] raw);
        if (raw == 9'd0)
            return 1;
        if (raw > MAX_SIDE)
            return MAX_SIDE;
        return 32'(raw);
    endfunction

    // Output size along one axis; factor zero passes the source size through.
    function automatic int unsigned out_dim(input logic [15:0] f, input int unsigned side);
        int unsigned n;
        if (f == 16'd0)
            return side;
        n = (f * side) >> 8;
        return (n > 65535) ? 65535 : n;
    endfunction

    // Pixels still to come in the frame under a candidate setting, or -1 when the scan
    // sits outside the output and would only answer empty.
    function automatic longint frame_left(input logic [8:0] w, input logic [8:0] h,
                                          input logic [15:0] f);
        longint ow;
        longint oh;
        ow = longint'(out_dim(f, side_of(w)));
        oh = longint'(out_dim(f, side_of(h)));
        if (frame_finished || scan_col >= ow || scan_row >= oh)
            return -1;
        return (ow - 1 - scan_col) * oh + (oh - scan_row);
    endfunction

    // Apply one accepted item to the shadow state and queue the pixel it causes.
    function automatic void predict_transfer(input logic func, input logic [31:0] pixel);
        int unsigned   sw;
        int unsigned   sh;
        int unsigned   ow;
        int unsigned   oh;
        int unsigned   sx;
        int unsigned   sy;
        scaled_pixel_t r;
        if (func == FUNC_LOAD)
        begin
            // Drop loads once the store is full.
            if (loaded_count < STORE_DEPTH)
            begin
                frame_pixels[loaded_count] = pixel;
                loaded_count++;
            end
            return;
        end
        sw = side_of(width_reg);
        sh = side_of(height_reg);
        ow = out_dim(factor_reg, sw);
        oh = out_dim(factor_reg, sh);
        r  = '{pixel: '0, col: '0, row: '0, is_last: 1'b0, is_empty: 1'b0};
        if (frame_finished || scan_col >= ow || scan_row >= oh)
        begin
            r.is_empty = 1'b1;
        end
        else
        begin
            sx = (factor_reg == 16'd0) ? scan_col : scan_col * 256 / factor_reg;
            sy = (factor_reg == 16'd0) ? scan_row : scan_row * 256 / factor_reg;
            if (sx >= sw)
                sx = sw - 1;
            if (sy >= sh)
                sy = sh - 1;
            r.pixel = frame_pixels[sy * sw + sx];
            r.col   = scan_col[15:0];
            r.row   = scan_row[15:0];
            // Scan column by column: the row advances fastest.
            if (scan_row + 1 < oh)
            begin
                scan_row++;
            end
            else
            begin
                scan_row = 0;
                if (scan_col + 1 < ow)
                begin
                    scan_col++;
                end
                else
                begin
                    r.is_last      = 1'b1;
                    frame_finished = 1'b1;
                    scan_col       = 0;
                end
            end
        end
        pixels_due.push_back(r);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued items, idle at random between them
    // ------------------------------------------------------------------

    // Record each input transfer and run the predictor on it.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_transfer(s_axis_tuser, s_axis_tdata);
            item_taken = 1'b1;
        end
    end

    // Hold an item until it transfers; then either present the next one or idle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || item_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_item.func;
                s_axis_tdata  <= next_item.pixel;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest predicted pixel
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixels_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing outstanding, expected none, actual 0x%0h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("pixel_out", want.pixel, m_axis_tdata[31:0]);
                check_field("out_x", 32'(want.col), 32'(m_axis_tdata[47:32]));
                check_field("out_y", 32'(want.row), 32'(m_axis_tdata[63:48]));
                check_field("last_pixel", 32'(want.is_last), 32'(m_axis_tlast));
                check_field("empty_res", 32'(want.is_empty), 32'(m_axis_tuser));
            end
        end
    end

    // Stall the result stream at random.
    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Watchdog: stop when nothing has moved on any channel for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // The write lands at this edge; mirror it in the shadow registers.
        case (index)
            CFG_SRC_WIDTH:  width_reg  = value[8:0];
            CFG_SRC_HEIGHT: height_reg = value[8:0];
            CFG_SCALE:      factor_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all three registers; the unused upper bits of the side words carry noise.
    task automatic set_scale(input logic [8:0] w, input logic [8:0] h, input logic [15:0] f);
        write_reg(CFG_SRC_WIDTH, {7'($urandom()), w});
        write_reg(CFG_SRC_HEIGHT, {7'($urandom()), h});
        write_reg(CFG_SCALE, f);
    endtask

    function automatic void queue_item(input logic func, input logic [31:0] pixel);
        pending_items.push_back('{func: func, pixel: pixel});
    endfunction

    // Wait until every item is taken and every pixel has arrived, then let a trailing
    // load finish inside the block.
    task automatic settle();
        @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [8:0] random_side();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(511, 257));
            4, 5, 6: return 9'($urandom_range(8, 1));
            default: return 9'($urandom_range(256, 1));
        endcase
    endfunction

    function automatic logic [15:0] random_factor();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            3:       return 16'($urandom_range(255, 1));
            4:       return 16'($urandom());
            default: return 16'($urandom_range(1024, 128));
        endcase
    endfunction

    // Batches of random requests with a sprinkle of loads, each under a fresh setting.
    // Pick settings that keep the frame open so the scan keeps moving and whose source
    // fits in the loaded part of the store; now and then accept one that parks the scan
    // outside the output.
    task automatic random_phase(input int gap_pct, input int stall_pct, input int wanted);
        int          done_requests;
        int          batch;
        int          tries;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [15:0] f;
        longint      left;
        logic        ok;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        done_requests  = 0;
        while (done_requests < wanted)
        begin
            batch = $urandom_range(40, 8);
            ok    = 1'b0;
            for (tries = 0; tries < 40 && !ok; tries++)
            begin
                w    = random_side();
                h    = random_side();
                f    = random_factor();
                left = frame_left(w, h, f);
                ok   = (left > batch && side_of(w) * side_of(h) <= loaded_count)
                       || (left < 0 && $urandom_range(7) == 0);
            end
            if (!ok)
            begin
                // Fall back to an empty output: nothing can finish the frame.
                w = 9'd1;
                h = 9'd1;
                f = 16'd1;
            end
            set_scale(w, h, f);
            for (int i = 0; i < batch; i++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    queue_item(FUNC_LOAD, $urandom());
                end
                else
                begin
                    queue_item(FUNC_REQUEST, $urandom());
                    done_requests++;
                end
            end
            settle();
        end
    endtask

    // Pick sizes whose last column is the current one and whose height leaves a few rows,
    // keeping the source inside the loaded part of the store, then run the frame out and
    // keep asking past its end.
    task automatic close_frame();
        int unsigned f;
        int unsigned w;
        int unsigned h;
        int unsigned k;
        int unsigned rows_left;
        logic        found;
        found     = 1'b0;
        rows_left = 1;
        f = (scan_col + 1 > scan_row + 4) ? scan_col + 1 : scan_row + 4;
        for (; f <= 65535 && !found; f++)
        begin
            w = ((scan_col + 1) * 256 + f - 1) / f;
            if (w > MAX_SIDE || out_dim(16'(f), w) != scan_col + 1)
                continue;
            for (k = 4; k >= 1 && !found; k--)
            begin
                h = ((scan_row + k) * 256 + f - 1) / f;
                if (h >= 1 && h <= MAX_SIDE && out_dim(16'(f), h) == scan_row + k
                    && w * h <= loaded_count)
                begin
                    found     = 1'b1;
                    rows_left = k;
                    set_scale(9'(w), 9'(h), 16'(f));
                end
            end
        end
        for (int i = 0; i < rows_left + 3; i++)
        begin
            queue_item(FUNC_REQUEST, $urandom());
            if (i == 1)
                queue_item(FUNC_LOAD, $urandom());
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SRC_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOAD;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty output: a zero width register acts as one, and a tiny factor rounds both
        // output sides to zero, so requests answer empty before anything is loaded.
        set_scale(9'd0, 9'd1, 16'd1);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        // Extreme pixel words land where the first reads look.
        queue_item(FUNC_LOAD, 32'hFFFF_FFFF);
        queue_item(FUNC_LOAD, 32'hA5A5_A5A5);
        queue_item(FUNC_LOAD, 32'h0000_0000);
        queue_item(FUNC_LOAD, 32'h5A5A_5A5A);
        settle();

        // Factor zero: 2x2 copied as is; walk the first column.
        set_scale(9'd2, 9'd2, 16'd0);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_REQUEST, 32'h0);
        settle();

        // Double size: the scan carries over from the previous setting.
        set_scale(9'd2, 9'd2, 16'd512);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_REQUEST, 32'h0);
        settle();

        // Scan beyond size: one output row leaves the scan row past the end. The width
        // register is above the largest side. Then load the store up to 256 pixels, so
        // any source of up to 256 pixels reads loaded entries only.
        set_scale(9'd511, 9'd1, 16'd256);
        queue_item(FUNC_REQUEST, 32'h0);
        for (int i = 0; i < 252; i++)
            queue_item(FUNC_LOAD, $urandom());
        settle();

        // Largest factor with oversized sides, then a pass-through on a 40x6 source.
        set_scale(9'd511, 9'd300, 16'hFFFF);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_REQUEST, 32'h0);
        settle();
        set_scale(9'd40, 9'd6, 16'd0);
        queue_item(FUNC_REQUEST, 32'h0);
        queue_item(FUNC_LOAD, 32'h1234_5678);
        queue_item(FUNC_REQUEST, 32'h0);
        settle();

        // Random part: receiver idles more, then sender, then neither.
        random_phase(21, 59, 100);
        random_phase(59, 21, 100);
        random_phase(0, 0, 100);

        // Frame finished: run out the frame and keep requesting.
        close_frame();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
